FILE: src/rgbsalu_pkg.sv
`timescale 1ns / 1ps

package rgbsalu_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned SCALE_W = 16;
	localparam int unsigned PROD_W = CHAN_W + SCALE_W;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_SUB   = 2'd1,
		KIND_MOD   = 2'd2,
		KIND_SCALE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ORDER_RGBA = 2'd0,
		ORDER_ARGB = 2'd1,
		ORDER_ABGR = 2'd2,
		ORDER_BGRA = 2'd3
	} order_t;

	// floor(p / 255), exact for p up to 255 * 255
	function automatic logic [CHAN_W-1:0] div255(input logic [15:0] p);
		logic [16:0] t;
		t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
		return t[15:8];
	endfunction

endpackage

FILE: src/rgbsalu_lane.sv
`timescale 1ns / 1ps

module rgbsalu_lane (
	input  logic                               clk,
	input  logic                               en_s1,
	input  rgbsalu_pkg::kind_t                 kind,
	input  logic [rgbsalu_pkg::CHAN_W-1:0]     x,
	input  logic [rgbsalu_pkg::CHAN_W-1:0]     y,
	input  logic signed [rgbsalu_pkg::SCALE_W-1:0] scale,
	output logic [rgbsalu_pkg::CHAN_W-1:0]     chan
);
	import rgbsalu_pkg::*;

	logic [CHAN_W:0]        sum;
	logic [CHAN_W-1:0]      addsub;
	logic [SCALE_W-1:0]     mul_b;
	logic [PROD_W-1:0]      prod;

	kind_t                  kind_s1;
	logic [CHAN_W-1:0]      addsub_s1;
	logic [PROD_W-1:0]      prod_s1;

	// first stage: add/subtract with clamp, one shared multiplier
	always_comb begin
		sum = {1'b0, x} + {1'b0, y};
		if (kind == KIND_ADD) begin
			addsub = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
		end else begin
			addsub = (x > y) ? (x - y) : '0;
		end
		case (kind)
			KIND_MOD:   mul_b = {{(SCALE_W-CHAN_W){1'b0}}, y};
			KIND_SCALE: mul_b = scale[SCALE_W-1] ? '0 : scale; // negative -> 0
			default:    mul_b = '0;
		endcase
		prod = {{SCALE_W{1'b0}}, x} * {{CHAN_W{1'b0}}, mul_b};
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1   <= kind;
			addsub_s1 <= addsub;
			prod_s1   <= prod;
		end
	end

	// second stage: pass add/subtract through, divide by 255, or drop the Q8.8 fraction and clamp
	always_comb begin
		case (kind_s1) inside
			KIND_ADD, KIND_SUB: chan = addsub_s1;
			KIND_MOD:           chan = div255(prod_s1[15:0]);
			default:            chan = (|prod_s1[PROD_W-1:16]) ? CHAN_MAX : prod_s1[15:8];
		endcase
	end

endmodule

FILE: src/rgbsalu_pack.sv
`timescale 1ns / 1ps

module rgbsalu_pack (
	input  rgbsalu_pkg::order_t              order,
	input  logic [rgbsalu_pkg::CHAN_W-1:0]   red,
	input  logic [rgbsalu_pkg::CHAN_W-1:0]   green,
	input  logic [rgbsalu_pkg::CHAN_W-1:0]   blue,
	input  logic [rgbsalu_pkg::CHAN_W-1:0]   alpha,
	output logic [4*rgbsalu_pkg::CHAN_W-1:0] packed_word
);
	import rgbsalu_pkg::*;

	always_comb begin
		unique case (order)
			ORDER_RGBA: packed_word = {red, green, blue, alpha};
			ORDER_ARGB: packed_word = {alpha, red, green, blue};
			ORDER_ABGR: packed_word = {alpha, blue, green, red};
			ORDER_BGRA: packed_word = {blue, green, red, alpha};
			default:    packed_word = {red, green, blue, alpha};
		endcase
	end

endmodule

FILE: src/rgba8_saturating_channel_alu_top.sv
`timescale 1ns / 1ps

// RGBA8 saturating channel ALU.
// Input channel (in_valid / in_stall): one transaction carries two colors a and b,
// a signed Q8.8 scale and the operation kind (add, subtract, modulate, scale).
// Output channel (out_valid / out_stall): one transaction per input, giving the
// four saturated channels and packed_res, the channels packed in pack_order.
// Config channel (cfg_valid / cfg_ready): writes pack_order; always ready.
// Write it only while no transaction is in flight.
// Two register stages: a transaction passes the lane register, then the output register, to out_valid.
// Four lanes, one per channel, each with one multiplier registered before the
// divide-by-255 / clamp step; that multiplier sets the cycle. Throughput: one
// transaction per cycle while out_stall is low.
// When the receiver stalls, the output register holds; the lane stage fills
// and then in_stall rises in the same cycle, so nothing is dropped.
// Reset clears the valid flags and sets pack_order to RGBA.
module rgba8_saturating_channel_alu_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  a_red,
	input  logic [7:0]  a_green,
	input  logic [7:0]  a_blue,
	input  logic [7:0]  a_alpha,
	input  logic [7:0]  b_red,
	input  logic [7:0]  b_green,
	input  logic [7:0]  b_blue,
	input  logic [7:0]  b_alpha,
	input  logic signed [15:0] scale,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	output logic [31:0] packed_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);
	import rgbsalu_pkg::*;

	order_t             pack_order_q;
	logic               valid_s1;
	logic               valid_s2;
	logic               en_s1;
	logic               en_s2;
	kind_t              kind_in;
	logic [CHAN_W-1:0]  red_c, green_c, blue_c, alpha_c;
	logic [31:0]        packed_c;
	logic [CHAN_W-1:0]  red_s2, green_s2, blue_s2, alpha_s2;
	logic [31:0]        packed_s2;

	// stage advances when empty or when the next one moves
	assign en_s2    = !valid_s2 || !out_stall;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;
	assign cfg_ready = 1'b1;
	assign kind_in  = kind_t'(kind);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_order_q <= ORDER_RGBA;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pack_order_q <= order_t'(cfg_data);
			end
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// one lane per channel
	rgbsalu_lane u_lane_red (
		.clk(clk), .en_s1(en_s1), .kind(kind_in), .x(a_red), .y(b_red),
		.scale(scale), .chan(red_c)
	);
	rgbsalu_lane u_lane_green (
		.clk(clk), .en_s1(en_s1), .kind(kind_in), .x(a_green), .y(b_green),
		.scale(scale), .chan(green_c)
	);
	rgbsalu_lane u_lane_blue (
		.clk(clk), .en_s1(en_s1), .kind(kind_in), .x(a_blue), .y(b_blue),
		.scale(scale), .chan(blue_c)
	);
	rgbsalu_lane u_lane_alpha (
		.clk(clk), .en_s1(en_s1), .kind(kind_in), .x(a_alpha), .y(b_alpha),
		.scale(scale), .chan(alpha_c)
	);

	// merge: byte ordering of the packed word
	rgbsalu_pack u_pack (
		.order(pack_order_q), .red(red_c), .green(green_c), .blue(blue_c),
		.alpha(alpha_c), .packed_word(packed_c)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en_s2) begin
			red_s2    <= red_c;
			green_s2  <= green_c;
			blue_s2   <= blue_c;
			alpha_s2  <= alpha_c;
			packed_s2 <= packed_c;
		end
	end

	assign out_valid  = valid_s2;
	assign out_red    = red_s2;
	assign out_green  = green_s2;
	assign out_blue   = blue_s2;
	assign out_alpha  = alpha_s2;
	assign packed_res = packed_s2;

	a_s1_moves_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && en_s2 |=> out_valid)
		else $error("lane stage transaction did not reach output");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty lane stage");

	a_pack_rgba: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pack_order_q == ORDER_RGBA
			|-> packed_res == {out_red, out_green, out_blue, out_alpha})
		else $error("packed word disagrees with channels");

endmodule
